/* design/scd_pkg.sv */
// Package for the scan cluster decimator: sizes, constants, register codes, states, arctan table.
package scd_pkg;

   localparam int SCAN_DEPTH = 2048;
   localparam int IDX_W      = $clog2(SCAN_DEPTH);

   localparam int RANGE_W    = 16;
   localparam int OUT_IDX_W  = 11;
   localparam int CSR_W      = 19;

   localparam int ANG_W      = 20;
   localparam int CRD_W      = 46;
   localparam int PT_W       = 24;
   localparam int SUM_W      = 36;
   localparam int CNT_W      = 12;
   localparam int MUL_W      = 26;
   localparam int RED_W      = 32;
   localparam int DVD_W      = 22;

   localparam int CORDIC_STEPS = 17;
   localparam int RED_TOP      = 12;
   localparam int COUNT_MAX    = 4095;

   localparam logic signed [RED_W-1:0] PI_Q16      = 32'sd205887;
   localparam logic signed [RED_W-1:0] TWO_PI_Q16  = 32'sd411775;
   localparam logic signed [RED_W-1:0] HALF_PI_Q16 = 32'sd102944;
   localparam logic signed [CRD_W-1:0] CORDIC_K    = 46'sd39797;

   typedef enum logic [2:0] {
      REG_CULL   = 3'd0,
      REG_MIXED  = 3'd1,
      REG_START  = 3'd2,
      REG_STEP   = 3'd3,
      REG_SINE   = 3'd4
   } csr_reg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ANG, ST_RED, ST_FOLD, ST_ROT, ST_MULX, ST_MULY, ST_DIFF,
      ST_SQX, ST_SQY, ST_LIM, ST_RDJ, ST_RDJ1, ST_RDP, ST_KEEPM, ST_AINIT,
      ST_ATAN, ST_DIVI, ST_DIV, ST_CLAMP, ST_RDQ, ST_EMITC, ST_OPEN, ST_ACC,
      ST_FIN
   } state_type;

   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] k);
      logic signed [ANG_W-1:0] a;
      case (k)
         5'd0:    a = 20'sd51472;
         5'd1:    a = 20'sd30386;
         5'd2:    a = 20'sd16055;
         5'd3:    a = 20'sd8150;
         5'd4:    a = 20'sd4091;
         5'd5:    a = 20'sd2047;
         5'd6:    a = 20'sd1024;
         5'd7:    a = 20'sd512;
         5'd8:    a = 20'sd256;
         5'd9:    a = 20'sd128;
         5'd10:   a = 20'sd64;
         5'd11:   a = 20'sd32;
         5'd12:   a = 20'sd16;
         5'd13:   a = 20'sd8;
         5'd14:   a = 20'sd4;
         5'd15:   a = 20'sd2;
         5'd16:   a = 20'sd1;
         default: a = 20'sd0;
      endcase
      return a;
   endfunction

endpackage

/* design/scd_if.sv */
// Word channels of the scan cluster decimator: sample requests and kept-index responses.
interface scd_req_if;
   import scd_pkg::*;
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_mm;
   logic               scan_end;
   modport source (output valid, output range_mm, output scan_end, input ready);
   modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

interface scd_rsp_if;
   import scd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] kept_index;
   logic [RANGE_W-1:0]   kept_range;
   logic                 last;
   modport source (output valid, output kept_index, output kept_range, output last,
                   input ready);
   modport sink   (input valid, input kept_index, input kept_range, input last,
                   output ready);
endinterface

/* design/scan_cluster_decimator.sv */
// Scan cluster decimator: one shared CORDIC, multiplier and divider under a sequencer.
// Takes one range word at a time and is busy until that word is done. Every sample runs
// the 13-step angle reduction and one 17-step CORDIC pass; a sample that closes a kept
// cluster can add a second 17-step CORDIC pass and the 22-step divider. Both CORDIC
// passes share one unit. Responses go out through a single register. A sample that must
// emit while an earlier response is still held stalls until that word is taken. The range
// store has no reset; no clearing pass is run.
module scan_cluster_decimator
   import scd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   scd_req_if.sink           req_chan,
   scd_rsp_if.source         rsp_chan,
   input  logic              csr_wen,
   input  logic [2:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   logic [RANGE_W-1:0] mem [SCAN_DEPTH];
   logic [RANGE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;

   state_type state_ff, state_in;

   logic [15:0] cull_ff, mixed_ff;
   logic signed [18:0] start_ff;
   logic [16:0] step_ff, sine_ff;

   logic [IDX_W-1:0] count_ff, count_in, first_idx_ff, first_idx_in, idx_ff, idx_in;
   logic open_ff, open_in, end_ff, end_in, neg_ff, neg_in, keep_ff, keep_in;
   logic [CNT_W-1:0] points_ff, points_in;
   logic signed [PT_W-1:0] fx_ff, fx_in, fy_ff, fy_in, px_ff, px_in, py_ff, py_in;
   logic signed [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [RANGE_W-1:0] r_ff, r_in, rj_ff, rj_in;
   logic signed [CRD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic signed [RED_W-1:0] red_ff, red_in;
   logic [4:0] k_ff, k_in;
   logic signed [PT_W:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [50:0] acc_ff, acc_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [17:0] rem_ff, rem_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [OUT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [RANGE_W-1:0] rsp_range_ff, rsp_range_in;

   logic signed [MUL_W-1:0] ma, mb;
   logic signed [2*MUL_W-1:0] prod;
   logic accept, out_free, last_step;
   logic signed [CRD_W-1:0] xs, ys;
   logic ccw;
   logic [16:0] den;
   logic [IDX_W-1:0] count_next, count_prev;

   function automatic logic [RANGE_W-1:0] absdiff(input logic [RANGE_W-1:0] a,
                                                  input logic [RANGE_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign last_step  = (k_ff == 5'(CORDIC_STEPS - 1));
   assign prod       = ma * mb;
   assign xs         = cx_ff >>> k_ff;
   assign ys         = cy_ff >>> k_ff;
   assign ccw        = (state_ff == ST_ROT) ? !z_ff[ANG_W-1]
                                            : !(!cy_ff[CRD_W-1] && (cy_ff != '0));
   assign den        = (step_ff == '0) ? 17'd1 : step_ff;
   assign count_next = (count_ff == IDX_W'(SCAN_DEPTH - 1)) ? '0 : count_ff + 1'b1;
   assign count_prev = (count_ff == '0) ? IDX_W'(SCAN_DEPTH - 1) : count_ff - 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kept_index = rsp_index_ff;
   assign rsp_chan.kept_range = rsp_range_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ANG;
         ST_ANG:   state_in = ST_RED;
         ST_RED:   if (k_ff == '0) state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_ROT;
         ST_ROT:   if (last_step) state_in = ST_MULX;
         ST_MULX:  state_in = ST_MULY;
         ST_MULY:  state_in = open_ff ? ST_DIFF : ST_OPEN;
         ST_DIFF:  state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_LIM;
         ST_LIM:   state_in = ((acc_ff > prod[50:0]) || end_ff) ? ST_RDJ : ST_ACC;
         ST_RDJ:   state_in = ST_RDJ1;
         ST_RDJ1:  state_in = ST_RDP;
         ST_RDP:   state_in = ST_KEEPM;
         ST_KEEPM: state_in = keep_in ? ST_AINIT : ST_OPEN;
         ST_AINIT: state_in = ((sx_ff == '0) && (sy_ff == '0)) ? ST_DIVI : ST_ATAN;
         ST_ATAN:  if (last_step) state_in = ST_DIVI;
         ST_DIVI:  state_in = z_in[ANG_W-1] ? ST_RDQ : ST_DIV;
         ST_DIV:   if (k_ff == '0) state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_RDQ;
         ST_RDQ:   state_in = ST_EMITC;
         ST_EMITC: if (out_free) state_in = ST_OPEN;
         ST_OPEN:  state_in = ST_FIN;
         ST_ACC:   state_in = ST_FIN;
         ST_FIN:   if (!end_ff || out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // handshake, memory address and multiplier operands
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      rd_addr = idx_ff;
      ma = '0;
      mb = '0;
      case (state_ff)
         ST_ANG: begin
            ma = MUL_W'($signed({1'b0, step_ff}));
            mb = MUL_W'($signed({1'b0, count_ff}));
         end
         ST_MULX: begin
            ma = MUL_W'($signed({1'b0, r_ff}));
            mb = neg_ff ? MUL_W'(-cx_ff) : MUL_W'(cx_ff);
         end
         ST_MULY: begin
            ma = MUL_W'($signed({1'b0, r_ff}));
            mb = neg_ff ? MUL_W'(-cy_ff) : MUL_W'(cy_ff);
         end
         ST_SQX: begin
            ma = MUL_W'(dx_ff);
            mb = MUL_W'(dx_ff);
         end
         ST_SQY: begin
            ma = MUL_W'(dy_ff);
            mb = MUL_W'(dy_ff);
         end
         ST_LIM: begin
            ma = MUL_W'($signed({1'b0, cull_ff, 6'b0}));
            mb = MUL_W'($signed({1'b0, cull_ff, 6'b0}));
         end
         ST_RDJ:  rd_addr = first_idx_ff;
         ST_RDJ1: rd_addr = first_idx_ff - 1'b1;
         ST_RDP:  rd_addr = count_prev;
         ST_KEEPM: begin
            ma = MUL_W'($signed({1'b0, rj_ff}));
            mb = MUL_W'($signed({1'b0, sine_ff}));
         end
         default: rd_addr = idx_ff;
      endcase
   end

   // datapath next values
   always_comb begin
      logic signed [RED_W-1:0] u, t, cmp;
      logic signed [2*MUL_W-1:0] rnd;
      logic signed [ANG_W:0] num;
      logic [18:0] remsh;
      logic [31:0] wide_idx;
      count_in = count_ff; first_idx_in = first_idx_ff; idx_in = idx_ff;
      open_in = open_ff; end_in = end_ff; neg_in = neg_ff; keep_in = keep_ff;
      points_in = points_ff; fx_in = fx_ff; fy_in = fy_ff; px_in = px_ff; py_in = py_ff;
      sx_in = sx_ff; sy_in = sy_ff; r_in = r_ff; rj_in = rj_ff;
      cx_in = cx_ff; cy_in = cy_ff; z_in = z_ff; red_in = red_ff; k_in = k_ff;
      dx_in = dx_ff; dy_in = dy_ff; acc_in = acc_ff;
      dvd_in = dvd_ff; quo_in = quo_ff; rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in = rsp_index_ff; rsp_range_in = rsp_range_ff; rsp_last_in = rsp_last_ff;
      u = '0; t = '0; cmp = '0; rnd = '0; num = '0; remsh = '0; wide_idx = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               r_in   = req_chan.range_mm;
               end_in = req_chan.scan_end;
            end
         end
         ST_ANG: begin
            u = RED_W'(start_ff) + prod[RED_W-1:0] + PI_Q16;
            if (u < 0) u = u + TWO_PI_Q16;
            red_in = u;
            k_in   = 5'(RED_TOP);
         end
         ST_RED: begin
            cmp = TWO_PI_Q16 <<< k_ff;
            if (red_ff >= cmp) red_in = red_ff - cmp;
            k_in = k_ff - 1'b1;
         end
         ST_FOLD: begin
            t = red_ff - PI_Q16;
            neg_in = 1'b0;
            if (t > HALF_PI_Q16) begin
               t = t - PI_Q16;
               neg_in = 1'b1;
            end else if (t < -HALF_PI_Q16) begin
               t = t + PI_Q16;
               neg_in = 1'b1;
            end
            z_in  = t[ANG_W-1:0];
            cx_in = CORDIC_K;
            cy_in = '0;
            k_in  = '0;
         end
         ST_ROT, ST_ATAN: begin
            if (ccw) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               z_in  = z_ff - atan_q16(k_ff);
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               z_in  = z_ff + atan_q16(k_ff);
            end
            k_in = k_ff + 1'b1;
         end
         ST_MULX: begin
            rnd   = (prod + 52'sd512) >>> 10;
            px_in = rnd[PT_W-1:0];
         end
         ST_MULY: begin
            rnd   = (prod + 52'sd512) >>> 10;
            py_in = rnd[PT_W-1:0];
         end
         ST_DIFF: begin
            dx_in = {px_ff[PT_W-1], px_ff} - {fx_ff[PT_W-1], fx_ff};
            dy_in = {py_ff[PT_W-1], py_ff} - {fy_ff[PT_W-1], fy_ff};
         end
         ST_SQX: acc_in = prod[50:0];
         ST_SQY: acc_in = acc_ff + prod[50:0];
         ST_RDJ1: begin
            rj_in   = rd_data_ff;
            keep_in = (points_ff > CNT_W'(1));
         end
         ST_RDP: begin
            if ((first_idx_ff != '0) && (absdiff(rj_ff, rd_data_ff) < mixed_ff))
               keep_in = 1'b1;
         end
         ST_KEEPM: begin
            if (absdiff(rd_data_ff, r_ff) < mixed_ff) keep_in = 1'b1;
            if ($unsigned(prod) > 52'({mixed_ff, 16'b0})) keep_in = 1'b1;
         end
         ST_AINIT: begin
            cx_in = {{2{sx_ff[SUM_W-1]}}, sx_ff, 8'b0};
            cy_in = {{2{sy_ff[SUM_W-1]}}, sy_ff, 8'b0};
            z_in  = '0;
            k_in  = '0;
            if (sx_ff[SUM_W-1]) begin
               if (!sy_ff[SUM_W-1]) begin
                  cx_in = {{2{sy_ff[SUM_W-1]}}, sy_ff, 8'b0};
                  cy_in = -{{2{sx_ff[SUM_W-1]}}, sx_ff, 8'b0};
                  z_in  = HALF_PI_Q16[ANG_W-1:0];
               end else begin
                  cx_in = -{{2{sy_ff[SUM_W-1]}}, sy_ff, 8'b0};
                  cy_in = {{2{sx_ff[SUM_W-1]}}, sx_ff, 8'b0};
                  z_in  = -HALF_PI_Q16[ANG_W-1:0];
               end
            end
         end
         ST_DIVI: begin
            num = {z_ff[ANG_W-1], z_ff} - (ANG_W+1)'(start_ff);
            z_in = num[ANG_W:1];
            if (num[ANG_W]) begin
               idx_in = '0;
               z_in[ANG_W-1] = 1'b1;
            end else begin
               z_in[ANG_W-1] = 1'b0;
            end
            dvd_in = {num[ANG_W-1:0], 1'b0} + DVD_W'(den);
            rem_in = '0;
            quo_in = '0;
            k_in   = 5'(DVD_W - 1);
         end
         ST_DIV: begin
            remsh = {rem_ff, dvd_ff[k_ff]};
            if (remsh >= {1'b0, den, 1'b0}) begin
               rem_in = 18'(remsh - {1'b0, den, 1'b0});
               quo_in = {quo_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = remsh[17:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b0};
            end
            k_in = k_ff - 1'b1;
         end
         ST_CLAMP: begin
            if (quo_ff > DVD_W'(count_ff)) idx_in = count_ff;
            else idx_in = quo_ff[IDX_W-1:0];
         end
         ST_EMITC: begin
            if (out_free) begin
               wide_idx     = 32'(idx_ff);
               rsp_valid_in = 1'b1;
               rsp_index_in = wide_idx[OUT_IDX_W-1:0];
               rsp_range_in = rd_data_ff;
               rsp_last_in  = 1'b0;
            end
         end
         ST_OPEN: begin
            first_idx_in = count_ff;
            fx_in = px_ff;
            fy_in = py_ff;
            sx_in = SUM_W'(px_ff);
            sy_in = SUM_W'(py_ff);
            points_in = CNT_W'(1);
            open_in = 1'b1;
         end
         ST_ACC: begin
            if (points_ff < CNT_W'(COUNT_MAX)) begin
               sx_in = sx_ff + SUM_W'(px_ff);
               sy_in = sy_ff + SUM_W'(py_ff);
               points_in = points_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!end_ff) begin
               count_in = count_next;
            end else if (out_free) begin
               wide_idx     = 32'(count_ff);
               rsp_valid_in = 1'b1;
               rsp_index_in = wide_idx[OUT_IDX_W-1:0];
               rsp_range_in = r_ff;
               rsp_last_in  = 1'b1;
               count_in  = '0;
               open_in   = 1'b0;
               points_in = '0;
               sx_in     = '0;
               sy_in     = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) mem[count_ff] <= req_chan.range_mm;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cull_ff      <= 16'd100;
         mixed_ff     <= 16'd400;
         start_ff     <= '0;
         step_ff      <= 17'd286;
         sine_ff      <= 17'd286;
         count_ff     <= '0;
         first_idx_ff <= '0;
         open_ff      <= 1'b0;
         points_ff    <= '0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_idx_ff <= first_idx_in;
         open_ff      <= open_in;
         points_ff    <= points_in;
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               REG_CULL:  cull_ff  <= csr_data[15:0];
               REG_MIXED: mixed_ff <= csr_data[15:0];
               REG_START: start_ff <= $signed(csr_data);
               REG_STEP:  step_ff  <= csr_data[16:0];
               REG_SINE:  sine_ff  <= csr_data[16:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      end_ff       <= end_in;
      neg_ff       <= neg_in;
      keep_ff      <= keep_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      r_ff         <= r_in;
      rj_ff        <= rj_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      z_ff         <= z_in;
      red_ff       <= red_in;
      k_ff         <= k_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      acc_ff       <= acc_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rsp_index_ff <= rsp_index_in;
      rsp_range_ff <= rsp_range_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

/* dv/tb_scan_cluster_decimator.sv */
// Testbench for the scan cluster decimator: scan stimulus, cluster predictor and response check.
`timescale 1ns / 1ps

module tb_scan_cluster_decimator;
   import scd_pkg::*;

   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic               scan_end;
   } sample_t;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] kept_index;
      logic [RANGE_W-1:0]   kept_range;
      logic                 last;
   } kept_t;

   localparam longint PI_L      = 205887;
   localparam longint TWO_PI_L  = 411775;
   localparam longint HALF_PI_L = 102944;
   localparam longint ARCTAN [CORDIC_STEPS] = '{51472, 30386, 16055, 8150, 4091, 2047,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

   logic clock;
   logic reset;
   logic csr_wen;
   logic [2:0] csr_index;
   logic [CSR_W-1:0] csr_data;

   scd_req_if req_chan();
   scd_rsp_if rsp_chan();

   scan_cluster_decimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state
   logic [RANGE_W-1:0] range_mem [SCAN_DEPTH];
   int unsigned        beam_count;
   int unsigned        first_beam;
   longint             first_x, first_y, centre_x, centre_y;
   int unsigned        point_count;
   bit                 cluster_live;
   logic [15:0]        cull_mm, mixed_mm;
   logic signed [18:0] start_ang;
   logic [16:0]        step_ang, step_sine;

   sample_t pending_samples [$];
   kept_t   kept_words [$];
   bit      req_took;
   int      send_gap, take_gap;
   int      failures, samples_sent, words_checked;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("tb_scan_cluster_decimator NOT OK");
      $finish;
   end

   function automatic void sin_cos(input longint a, output longint c, output longint s);
      longint t, x, y, dx, dy;
      bit neg;
      neg = 1'b0;
      t = (a + PI_L) % TWO_PI_L;
      if (t < 0) t += TWO_PI_L;
      t -= PI_L;
      if (t > HALF_PI_L) begin
         t -= PI_L;
         neg = 1'b1;
      end else if (t < -HALF_PI_L) begin
         t += PI_L;
         neg = 1'b1;
      end
      x = 39797;
      y = 0;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (t >= 0) begin
            x -= dx; y += dy; t -= ARCTAN[k];
         end else begin
            x += dx; y -= dy; t += ARCTAN[k];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endfunction

   function automatic longint centroid_angle(input longint sy, input longint sx);
      longint x, y, z, t, nx;
      if (sx == 0 && sy == 0) return 0;
      x = sx * 256;
      y = sy * 256;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI_L;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI_L;
         end
      end
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (y > 0) begin
            nx = x + (y >>> k); y -= x >>> k; z += ARCTAN[k];
         end else begin
            nx = x - (y >>> k); y += x >>> k; z -= ARCTAN[k];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint range_gap(input longint a, input longint b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic void start_cluster(input int unsigned i, input longint px,
                                         input longint py);
      first_beam   = i;
      first_x      = px;
      first_y      = py;
      centre_x     = px;
      centre_y     = py;
      point_count  = 1;
      cluster_live = 1'b1;
   endfunction

   function automatic void predict_sample(input sample_t smp);
      int unsigned i, j, prev;
      longint r, rj, ang, c, s, px, py, dx, dy, lim, th, num, den, q;
      bit keep;
      kept_t w;
      r = smp.range_mm;
      i = beam_count % SCAN_DEPTH;
      range_mem[i] = smp.range_mm;
      ang = longint'(start_ang) + longint'(step_ang) * longint'(i);
      sin_cos(ang, c, s);
      px = (r * c + 512) >>> 10;
      py = (r * s + 512) >>> 10;
      if (!cluster_live) begin
         start_cluster(i, px, py);
      end else begin
         dx = px - first_x;
         dy = py - first_y;
         lim = longint'(cull_mm) * 64;
         if (dx * dx + dy * dy > lim * lim || smp.scan_end) begin
            j = first_beam % SCAN_DEPTH;
            prev = (i + SCAN_DEPTH - 1) % SCAN_DEPTH;
            rj = range_mem[j];
            keep = point_count > 1;
            if (j > 0 && range_gap(rj, range_mem[j-1]) < mixed_mm) keep = 1'b1;
            if (range_gap(range_mem[prev], r) < mixed_mm) keep = 1'b1;
            if (rj * longint'(step_sine) > (longint'(mixed_mm) << 16)) keep = 1'b1;
            if (keep) begin
               th = centroid_angle(centre_y, centre_x);
               num = th - longint'(start_ang);
               den = step_ang != 0 ? longint'(step_ang) : 1;
               if (num >= 0) q = (2 * num + den) / (2 * den);
               else q = -((-2 * num + den) / (2 * den));
               if (q < 0) q = 0;
               if (q > longint'(i)) q = i;
               w.kept_index = q[OUT_IDX_W-1:0];
               w.kept_range = range_mem[q % SCAN_DEPTH];
               w.last       = 1'b0;
               kept_words.push_back(w);
            end
            start_cluster(i, px, py);
         end else if (point_count < COUNT_MAX) begin
            centre_x += px;
            centre_y += py;
            point_count++;
         end
      end
      if (smp.scan_end) begin
         w.kept_index = i[OUT_IDX_W-1:0];
         w.kept_range = smp.range_mm;
         w.last       = 1'b1;
         kept_words.push_back(w);
         beam_count   = 0;
         cluster_live = 1'b0;
         point_count  = 0;
         centre_x     = 0;
         centre_y     = 0;
      end else begin
         beam_count = (i + 1) % SCAN_DEPTH;
      end
   endfunction

   // acceptance, prediction and response check
   always @(posedge clock) begin
      kept_t want;
      req_took <= req_chan.valid && req_chan.ready && !reset;
      if (!reset && csr_wen) begin
         case (csr_reg_type'(csr_index))
            REG_CULL:  cull_mm   = csr_data[15:0];
            REG_MIXED: mixed_mm  = csr_data[15:0];
            REG_START: start_ang = csr_data[18:0];
            REG_STEP:  step_ang  = csr_data[16:0];
            REG_SINE:  step_sine = csr_data[16:0];
            default: ;
         endcase
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_sample('{req_chan.range_mm, req_chan.scan_end});
         samples_sent++;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (kept_words.size() == 0) begin
            $display("%0t: unexpected word idx=%0d range=%0d last=%0b", $time,
                     rsp_chan.kept_index, rsp_chan.kept_range, rsp_chan.last);
            failures++;
         end else begin
            want = kept_words.pop_front();
            words_checked++;
            if (rsp_chan.kept_index !== want.kept_index) begin
               $display("%0t: kept_index expected %0d actual %0d", $time,
                        want.kept_index, rsp_chan.kept_index);
               failures++;
            end
            if (rsp_chan.kept_range !== want.kept_range) begin
               $display("%0t: kept_range expected %0d actual %0d", $time,
                        want.kept_range, rsp_chan.kept_range);
               failures++;
            end
            if (rsp_chan.last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time,
                        want.last, rsp_chan.last);
               failures++;
            end
         end
      end
   end

   // sample driver and response back-pressure
   always @(negedge clock) begin
      sample_t smp;
      if (!reset) begin
         if (!req_chan.valid || req_took) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap) begin
               smp = pending_samples.pop_front();
               req_chan.valid    <= 1'b1;
               req_chan.range_mm <= smp.range_mm;
               req_chan.scan_end <= smp.scan_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= take_gap);
      end
   end

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_wen   = 1'b0;
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || req_chan.valid || kept_words.size() > 0)
         @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic set_regs(input int cull, input int mixed, input int start,
                           input int step, input int sine);
      write_reg(REG_CULL, CSR_W'(cull));
      write_reg(REG_MIXED, CSR_W'(mixed));
      write_reg(REG_START, CSR_W'(start));
      write_reg(REG_STEP, CSR_W'(step));
      write_reg(REG_SINE, CSR_W'(sine));
   endtask

   task automatic push_sample(input int r, input bit last);
      pending_samples.push_back('{r[15:0], last});
   endtask

   // smooth runs with jumps and lone points, closed by scan end
   task automatic add_scan(input int len);
      int r;
      r = $urandom_range(65535);
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(9))
            0, 1: r = $urandom_range(65535);
            2:    r = (r + $urandom_range(3000)) % 65536;
            default: begin
               r = r + $urandom_range(80) - 40;
               if (r < 0) r = 0;
               if (r > 65535) r = 65535;
            end
         endcase
         push_sample(r, k == len - 1);
      end
   endtask

   task automatic random_phase(input int count);
      int left;
      left = count;
      while (left > 0) begin
         int len;
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(60, 2);
         if (len > left) len = left;
         if ($urandom_range(15) == 0) begin
            push_sample($urandom_range(65535), $urandom_range(1));
            left--;
         end else begin
            add_scan(len);
            left -= len;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_wen        = 1'b0;
      csr_index      = 3'd0;
      csr_data       = '0;
      req_chan.valid = 1'b0;
      req_chan.range_mm = '0;
      req_chan.scan_end = 1'b0;
      rsp_chan.ready = 1'b0;
      req_took       = 1'b0;
      failures = 0; samples_sent = 0; words_checked = 0;
      send_gap = 25; take_gap = 70;
      beam_count = 0; first_beam = 0; first_x = 0; first_y = 0;
      centre_x = 0; centre_y = 0; point_count = 0; cluster_live = 1'b0;
      cull_mm = 100; mixed_mm = 400; start_ang = '0; step_ang = 286; step_sine = 286;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, lone sample scan, zero centroid, tight clusters
      push_sample(65535, 1'b1);
      push_sample(0, 1'b0); push_sample(0, 1'b0); push_sample(0, 1'b1);
      push_sample(65535, 1'b0); push_sample(0, 1'b0); push_sample(65535, 1'b0);
      push_sample(1000, 1'b0); push_sample(1010, 1'b0); push_sample(1020, 1'b0);
      push_sample(30000, 1'b0); push_sample(500, 1'b0); push_sample(65535, 1'b1);
      push_sample(5000, 1'b0); push_sample(5000, 1'b1);
      drain();

      // extremes: widest limits, steepest start, smallest nonzero step
      set_regs(65535, 65535, 205887, 1, 65536);
      push_sample(65535, 1'b0); push_sample(0, 1'b0); push_sample(32768, 1'b1);
      send_gap = 25; take_gap = 70;
      random_phase(200);
      drain();

      // zero limits, zero step, most negative start
      set_regs(0, 0, -205887, 0, 0);
      push_sample(200, 1'b0); push_sample(200, 1'b0); push_sample(65535, 1'b0);
      push_sample(0, 1'b1);
      random_phase(200);
      drain();

      set_regs(300, 1000, -102944, 1200, 1200);
      send_gap = 70; take_gap = 25;
      random_phase(220);
      drain();

      set_regs(2000, 50, 150000, 65536, 65536);
      random_phase(200);
      drain();

      set_regs(100, 400, 0, 286, 286);
      send_gap = 0; take_gap = 0;
      random_phase(220);
      drain();

      // random register setting
      set_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(411774) - 205887,
               $urandom_range(65536, 1), $urandom_range(65536));
      random_phase(190);
      drain();

      $display("covered %0d samples and %0d response words over several register settings,",
               samples_sent, words_checked);
      $display("including lone samples, zero step, extreme angles and stalled responses");
      if (failures == 0 && kept_words.size() == 0)
         $display("tb_scan_cluster_decimator OK");
      else
         $display("tb_scan_cluster_decimator NOT OK");
      $finish;
   end

endmodule
